// ===== hw/rtl/ppu_mode_timing_with_vram_lockout_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef PPU_MODE_TIMING_WITH_VRAM_LOCKOUT_UNIT_MACROS_SVH
`define PPU_MODE_TIMING_WITH_VRAM_LOCKOUT_UNIT_MACROS_SVH

// property checked only outside reset
`define PMTVL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define PMTVL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pmtvl_pkg.sv =====
package pmtvl_pkg;

    localparam int unsigned VRAM_BYTES_DEF = 8192;
    localparam int unsigned OAM_BYTES_DEF  = 160;

    localparam int unsigned ADDR_W   = 13;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned LINE_W   = 8;
    localparam int unsigned PHASE_W  = 7;
    // wide enough for an address compared against the largest vram size times eight
    localparam int unsigned WIDE_W   = 18;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [LINE_W-1:0]  LINES_VISIBLE = 8'd144;
    localparam logic [LINE_W-1:0]  LINE_LAST     = 8'd153;
    localparam logic [PHASE_W-1:0] LIMIT_HBLANK  = 7'(51 - 1);
    localparam logic [PHASE_W-1:0] LIMIT_VBLANK  = 7'(114 - 1);
    localparam logic [PHASE_W-1:0] LIMIT_SEARCH  = 7'(20 - 1);
    localparam logic [PHASE_W-1:0] LIMIT_DRAW    = 7'(43 - 1);
    localparam logic [DATA_W-1:0]  BYTE_LOCKED   = 8'hFF;

    typedef enum logic [2:0] {
        MODE_HBLANK = 3'd0,
        MODE_VBLANK = 3'd1,
        MODE_SEARCH = 3'd2,
        MODE_DRAW   = 3'd3,
        MODE_OFF    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_VRAM_RD = 3'd1,
        OP_VRAM_WR = 3'd2,
        OP_OAM_RD  = 3'd3,
        OP_OAM_WR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_LINE_COMPARE   = 2'd0,
        CFG_COMPARE_IRQ_EN = 2'd1,
        CFG_SEARCH_IRQ_EN  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RSEL_ZERO = 2'd0,
        RSEL_FF   = 2'd1,
        RSEL_VRAM = 2'd2,
        RSEL_OAM  = 2'd3
    } rsel_t;

    typedef struct packed {
        logic              we;
        logic [1:0]        index;
        logic [DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        mode_t              mode;
        logic [LINE_W-1:0]  line;
        logic [PHASE_W-1:0] phase;
        logic               irq;
    } view_t;

endpackage

// ===== hw/rtl/ppu_mode_timing_with_vram_lockout_unit.sv =====
// a word goes through stage 1 and the stage 2 output register to the result channel
// throughput: one word per cycle unless the sink stalls; ticks and accesses of any
// mix follow back to back. reset: aresetn low clears timing, config and pipeline;
// then a clearing pass of the vram range zeroes vram and oam, s_tready low throughout
// config writes are taken at any time, cfg_ready is always high
module ppu_mode_timing_with_vram_lockout_unit
    import pmtvl_pkg::*;
#(
    parameter int unsigned VRAM_BYTES = VRAM_BYTES_DEF,
    parameter int unsigned OAM_BYTES  = OAM_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // lcd_on[0], addr[13:1], write_data[21:14]
    input  logic [S_TUSER_W-1:0] s_tuser,   // op[2:0]
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // mode[2:0], line[10:3], dot_phase[17:11],
                                            // stat_irq[18], read_data[26:19]
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int unsigned VRAM_AW = $clog2(VRAM_BYTES);
    localparam int unsigned OAM_AW  = $clog2(OAM_BYTES);

    // unpacked input word
    op_t                op;
    logic               lcd_on;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  wdata;
    logic               accept;

    // timing unit
    cfg_wr_t            cfg_wr;
    mode_t              cur_mode;
    view_t              view;

    // locks and address decode
    logic               vlock;
    logic               olock;
    logic               oam_in_range;
    logic [WIDE_W-1:0]  vram_rem;
    logic [VRAM_AW-1:0] vram_idx;
    rsel_t              rsel;

    // memory ports
    logic               vram_we, vram_re;
    logic [VRAM_AW-1:0] vram_waddr;
    logic [DATA_W-1:0]  vram_wdata, vram_rdata;
    logic               oam_we, oam_re;
    logic [OAM_AW-1:0]  oam_waddr;
    logic [DATA_W-1:0]  oam_wdata, oam_rdata;

    // clearing pass after reset
    logic               clr_active_reg, clr_active_next;
    logic [VRAM_AW-1:0] clr_idx_reg, clr_idx_next;
    logic               clr_oam;

    // stage 1: memory read in flight
    logic               s1_valid_reg, s1_valid_next;
    view_t              s1_view_reg, s1_view_next;
    rsel_t              s1_rsel_reg, s1_rsel_next;
    logic               s1_adv;

    // stage 2: output register
    logic               s2_valid_reg, s2_valid_next;
    view_t              s2_view_reg, s2_view_next;
    logic [DATA_W-1:0]  s2_rd_reg, s2_rd_next;
    logic               s2_free;

    assign op     = op_t'(s_tuser[2:0]);
    assign lcd_on = s_tdata[0];
    assign addr   = s_tdata[13:1];
    assign wdata  = s_tdata[21:14];

    // the pipeline frees a slot whenever stage 1 is empty or moves on
    assign s2_free  = !s2_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_tready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    assign cfg_ready     = 1'b1;
    assign cfg_wr.we     = cfg_valid;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;

    pmtvl_timing u_timing (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick_en  (accept && (op == OP_TICK)),
        .lcd_on   (lcd_on),
        .cfg_wr   (cfg_wr),
        .cur_mode (cur_mode),
        .view     (view)
    );

    // locks follow the mode held before the word
    assign vlock        = (cur_mode == MODE_DRAW);
    assign olock        = (cur_mode == MODE_DRAW) || (cur_mode == MODE_SEARCH);
    assign oam_in_range = WIDE_W'(addr) < WIDE_W'(OAM_BYTES);

    // vram address wraps modulo the size: four conditional subtracts cover
    // any size of at least 1024 bytes against a 13-bit address
    always_comb begin
        vram_rem = WIDE_W'(addr);
        for (int k = 3; k >= 0; k--) begin
            if (vram_rem >= WIDE_W'(VRAM_BYTES << k)) begin
                vram_rem = WIDE_W'(vram_rem - WIDE_W'(VRAM_BYTES << k));
            end
        end
        vram_idx = vram_rem[VRAM_AW-1:0];
    end

    // read source for the result word
    always_comb begin
        case (op)
            OP_VRAM_RD: rsel = vlock ? RSEL_FF : RSEL_VRAM;
            OP_OAM_RD:  rsel = (olock || !oam_in_range) ? RSEL_FF : RSEL_OAM;
            default:    rsel = RSEL_ZERO;
        endcase
    end

    // clearing pass walks the vram range and zeroes oam on the way
    assign clr_oam = WIDE_W'(clr_idx_reg) < WIDE_W'(OAM_BYTES);

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg) begin
            if (clr_idx_reg == VRAM_AW'(VRAM_BYTES - 1)) begin
                clr_active_next = 1'b0;
            end else begin
                clr_idx_next = VRAM_AW'(clr_idx_reg + 1'b1);
            end
        end
    end

    // memory port muxing between the clearing pass and accesses
    always_comb begin
        if (clr_active_reg) begin
            vram_we    = 1'b1;
            vram_waddr = clr_idx_reg;
            vram_wdata = '0;
            oam_we     = clr_oam;
            oam_waddr  = clr_idx_reg[OAM_AW-1:0];
            oam_wdata  = '0;
        end else begin
            vram_we    = accept && (op == OP_VRAM_WR) && !vlock;
            vram_waddr = vram_idx;
            vram_wdata = wdata;
            oam_we     = accept && (op == OP_OAM_WR) && !olock && oam_in_range;
            oam_waddr  = addr[OAM_AW-1:0];
            oam_wdata  = wdata;
        end
    end

    assign vram_re = accept && (op == OP_VRAM_RD);
    assign oam_re  = accept && (op == OP_OAM_RD) && oam_in_range;

    pmtvl_ram #(
        .DEPTH (VRAM_BYTES)
    ) u_vram (
        .aclk    (aclk),
        .wr_en   (vram_we),
        .wr_addr (vram_waddr),
        .wr_data (vram_wdata),
        .rd_en   (vram_re),
        .rd_addr (vram_idx),
        .rd_data (vram_rdata)
    );

    pmtvl_ram #(
        .DEPTH (OAM_BYTES)
    ) u_oam (
        .aclk    (aclk),
        .wr_en   (oam_we),
        .wr_addr (oam_waddr),
        .wr_data (oam_wdata),
        .rd_en   (oam_re),
        .rd_addr (addr[OAM_AW-1:0]),
        .rd_data (oam_rdata)
    );

    // stage 1 takes the word's timing view and read source
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_view_next  = s1_view_reg;
        s1_rsel_next  = s1_rsel_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_view_next  = view;
            s1_rsel_next  = rsel;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    // stage 2 merges the read byte, held while the sink stalls
    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_view_next  = s2_view_reg;
        s2_rd_next    = s2_rd_reg;
        if (s1_adv) begin
            s2_valid_next = 1'b1;
            s2_view_next  = s1_view_reg;
            case (s1_rsel_reg)
                RSEL_FF:   s2_rd_next = BYTE_LOCKED;
                RSEL_VRAM: s2_rd_next = vram_rdata;
                RSEL_OAM:  s2_rd_next = oam_rdata;
                default:   s2_rd_next = '0;
            endcase
        end else if (m_tready) begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_view_reg <= s1_view_next;
        s1_rsel_reg <= s1_rsel_next;
        s2_view_reg <= s2_view_next;
        s2_rd_reg   <= s2_rd_next;
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {5'b0, s2_rd_reg, s2_view_reg.irq, s2_view_reg.phase,
                       s2_view_reg.line, s2_view_reg.mode};

endmodule

// ===== hw/rtl/pmtvl_ram.sv =====
module pmtvl_ram
    import pmtvl_pkg::*;
#(
    parameter int unsigned DEPTH = OAM_BYTES_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pmtvl_timing.sv =====
module pmtvl_timing
    import pmtvl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick_en,
    input  logic              lcd_on,
    input  cfg_wr_t           cfg_wr,
    output mode_t             cur_mode,
    output view_t             view
);

    mode_t              mode_reg, mode_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] limit_reg, limit_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [LINE_W-1:0]  lcmp_reg, lcmp_next;
    logic               cie_reg, cie_next;
    logic               sie_reg, sie_next;

    logic               enter_search;
    logic               run;
    logic [PHASE_W-1:0] ph;

    // config registers
    always_comb begin
        lcmp_next = lcmp_reg;
        cie_next  = cie_reg;
        sie_next  = sie_reg;
        if (cfg_wr.we) begin
            case (cfg_idx_t'(cfg_wr.index))
                CFG_LINE_COMPARE:   lcmp_next = cfg_wr.data;
                CFG_COMPARE_IRQ_EN: cie_next  = cfg_wr.data[0];
                CFG_SEARCH_IRQ_EN:  sie_next  = cfg_wr.data[0];
                default: ;
            endcase
        end
    end

    // next state of the mode sequencer
    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        limit_next   = limit_reg;
        line_next    = line_reg;
        enter_search = 1'b0;
        run          = 1'b0;
        ph           = phase_reg;
        if (tick_en) begin
            if (mode_reg == MODE_OFF) begin
                run = lcd_on;
                ph  = '0;
            end else if (!lcd_on) begin
                mode_next = MODE_OFF;
            end else begin
                run = 1'b1;
            end
            if (run) begin
                if (ph == '0) begin
                    case (mode_reg)
                        MODE_OFF: begin
                            line_next    = '0;
                            enter_search = 1'b1;
                        end
                        MODE_HBLANK: begin
                            line_next = LINE_W'(line_reg + 1'b1);
                            if (line_next < LINES_VISIBLE) begin
                                enter_search = 1'b1;
                            end else begin
                                mode_next  = MODE_VBLANK;
                                limit_next = LIMIT_VBLANK;
                            end
                        end
                        MODE_VBLANK: begin
                            if (line_reg < LINE_LAST) begin
                                line_next = LINE_W'(line_reg + 1'b1);
                            end else begin
                                line_next    = '0;
                                enter_search = 1'b1;
                            end
                        end
                        MODE_SEARCH: begin
                            mode_next  = MODE_DRAW;
                            limit_next = LIMIT_DRAW;
                        end
                        default: begin
                            mode_next  = MODE_HBLANK;
                            limit_next = LIMIT_HBLANK;
                        end
                    endcase
                    if (enter_search) begin
                        mode_next  = MODE_SEARCH;
                        limit_next = LIMIT_SEARCH;
                    end
                end
                phase_next = (ph == limit_next) ? '0 : PHASE_W'(ph + 1'b1);
            end
        end
    end

    // outputs
    always_comb begin
        cur_mode   = mode_reg;
        view.mode  = mode_next;
        view.line  = line_next;
        view.phase = phase_next;
        view.irq   = enter_search && (((line_next == lcmp_reg) && cie_reg) || sie_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OFF;
            phase_reg <= '0;
            limit_reg <= '0;
            line_reg  <= '0;
            lcmp_reg  <= '0;
            cie_reg   <= 1'b0;
            sie_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            limit_reg <= limit_next;
            line_reg  <= line_next;
            lcmp_reg  <= lcmp_next;
            cie_reg   <= cie_next;
            sie_reg   <= sie_next;
        end
    end

endmodule

// ===== hw/rtl/pmtvl_checker.sv =====
`include "ppu_mode_timing_with_vram_lockout_unit_macros.svh"

module pmtvl_checker
    import pmtvl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result word holds
    `PMTVL_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // reset empties the pipeline and starts the clearing pass
    `PMTVL_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid && !s_tready, "not quiet after reset")

    // timing fields stay within their ranges
    `PMTVL_ASSERT(a_range, aclk, aresetn, m_tvalid |-> (m_tdata[2:0] <= MODE_OFF) && (m_tdata[10:3] <= 8'd153) && (m_tdata[17:11] <= 7'd113), "timing field out of range")

    // an interrupt request only comes with the first tick of oam search
    `PMTVL_ASSERT(a_irq, aclk, aresetn, m_tvalid && m_tdata[18] |-> (m_tdata[2:0] == MODE_SEARCH) && (m_tdata[17:11] == 7'd1) && (m_tdata[26:19] == 8'd0), "interrupt outside search entry")

endmodule

bind ppu_mode_timing_with_vram_lockout_unit pmtvl_checker u_pmtvl_checker (.*);

// ===== dv/tb.sv =====
module tb;
    import pmtvl_pkg::*;

    localparam int unsigned VRAM_SIZE = VRAM_BYTES_DEF;
    localparam int unsigned OAM_SIZE  = OAM_BYTES_DEF;

    // op codes the block leaves unused, reported as no-ops
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // one predicted result word
    typedef struct packed {
        mode_t       mode;
        logic [7:0]  line;
        logic [6:0]  dot;
        logic        irq;
        logic [7:0]  rd;
    } lcd_status_t;

    // timing and memory predictor plus the queue of results still owed by the block
    class lcd_timing_scoreboard;
        logic [7:0]  line_cmp;
        logic        cmp_irq_en;
        logic        search_irq_en;
        mode_t       mode;
        logic [6:0]  dot;
        logic [6:0]  dot_limit;
        logic [7:0]  ly;
        logic [7:0]  vram [VRAM_SIZE];
        logic [7:0]  oam [OAM_SIZE];
        lcd_status_t owed_status[$];
        int          errors, checked, words_in, irqs, refused_reads, deepest_line;
        bit [4:0]    modes_seen;

        function new();
            line_cmp = '0;
            cmp_irq_en = 1'b0;
            search_irq_en = 1'b0;
            mode = MODE_OFF;
            dot = '0;
            dot_limit = '0;
            ly = '0;
            foreach (vram[i]) vram[i] = '0;
            foreach (oam[i]) oam[i] = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] v);
            case (idx)
                CFG_LINE_COMPARE:   line_cmp = v;
                CFG_COMPARE_IRQ_EN: cmp_irq_en = v[0];
                CFG_SEARCH_IRQ_EN:  search_irq_en = v[0];
                default: ;
            endcase
        endfunction

        // switch mode, load its length, report a stat request on search entry
        function logic start_mode(mode_t m);
            mode = m;
            case (m)
                MODE_HBLANK: dot_limit = LIMIT_HBLANK;
                MODE_VBLANK: dot_limit = LIMIT_VBLANK;
                MODE_SEARCH: begin
                    dot_limit = LIMIT_SEARCH;
                    return (ly == line_cmp && cmp_irq_en) || search_irq_en;
                end
                default: dot_limit = LIMIT_DRAW;
            endcase
            return 1'b0;
        endfunction

        function logic next_mode();
            case (mode)
                MODE_OFF: begin
                    ly = '0;
                    return start_mode(MODE_SEARCH);
                end
                MODE_HBLANK: begin
                    ly = ly + 8'd1;
                    return start_mode(ly < LINES_VISIBLE ? MODE_SEARCH : MODE_VBLANK);
                end
                MODE_VBLANK: begin
                    if (ly < LINE_LAST) begin
                        ly = ly + 8'd1;
                        return 1'b0;
                    end
                    ly = '0;
                    return start_mode(MODE_SEARCH);
                end
                MODE_SEARCH: return start_mode(MODE_DRAW);
                default: return start_mode(MODE_HBLANK);
            endcase
        endfunction

        function logic tick(logic on);
            logic irq;
            irq = 1'b0;
            if (mode == MODE_OFF) begin
                if (!on) return 1'b0;
                dot = '0;
            end else if (!on) begin
                mode = MODE_OFF;
                return 1'b0;
            end
            if (dot == '0) irq = next_mode();
            dot = (dot == dot_limit) ? '0 : dot + 7'd1;
            return irq;
        endfunction

        function void note_word(logic [2:0] op, logic on, logic [12:0] addr, logic [7:0] wd);
            lcd_status_t s;
            logic vlock, olock;
            vlock = (mode == MODE_DRAW);
            olock = (mode == MODE_DRAW || mode == MODE_SEARCH);
            s.irq = 1'b0;
            s.rd = '0;
            case (op)
                OP_TICK:    s.irq = tick(on);
                OP_VRAM_RD: s.rd = vlock ? BYTE_LOCKED : vram[addr];
                OP_VRAM_WR: if (!vlock) vram[addr] = wd;
                OP_OAM_RD:  s.rd = (olock || addr >= OAM_SIZE) ? BYTE_LOCKED : oam[addr];
                OP_OAM_WR:  if (!olock && addr < OAM_SIZE) oam[addr] = wd;
                default: ;
            endcase
            if ((op == OP_VRAM_RD && vlock) ||
                (op == OP_OAM_RD && (olock || addr >= OAM_SIZE)))
                refused_reads++;
            s.mode = mode;
            s.line = ly;
            s.dot = dot;
            owed_status = {owed_status, s};
            words_in++;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] w);
            lcd_status_t e;
            if (owed_status.size() == 0) begin
                $error("result word arrived with nothing expected: %h", w);
                errors++;
                return;
            end
            e = owed_status.pop_front();
            cmp_field("mode", e.mode, w[2:0]);
            cmp_field("line", e.line, w[10:3]);
            cmp_field("dot_phase", e.dot, w[17:11]);
            cmp_field("stat_irq", e.irq, w[18]);
            cmp_field("read_data", e.rd, w[26:19]);
            checked++;
            if (e.irq) irqs++;
            if (e.line > deepest_line) deepest_line = e.line;
            modes_seen[e.mode] = 1'b1;
        endfunction

        function int pending();
            return owed_status.size();
        endfunction
    endclass

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // input side
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // lcd_on[0], addr[13:1], write_data[21:14]
    logic [S_TUSER_W-1:0] s_tuser = '0;   // op[2:0]

    // result side
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // mode[2:0], line[10:3], dot_phase[17:11],
                                         // stat_irq[18], read_data[26:19]

    // register writes
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    lcd_timing_scoreboard sb = new();

    // pacing controls shared with the receiver process
    bit quiet = 1'b0;           // no idling on either side while set
    int long_holds_asked = 0;   // bumped by the stimulus to request a long back-pressure
    int rx_holds_seen = 0;
    int rx_hold_left = 0;

    ppu_mode_timing_with_vram_lockout_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver pacing: mostly ready, short stalls, a few long ones,
    // and a long hold whenever the stimulus asks for one
    always @(posedge aclk) begin
        logic ready_next;
        int r;
        if (rx_hold_left > 0) begin
            ready_next = 1'b0;
            rx_hold_left--;
        end else if (long_holds_asked != rx_holds_seen) begin
            // long hold so the pipeline fills and s_tready drops
            rx_holds_seen++;
            rx_hold_left = 400 - 1;
            ready_next = 1'b0;
        end else if (quiet) begin
            ready_next = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                ready_next = 1'b1;
            end else begin
                ready_next = 1'b0;
                rx_hold_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
        m_tready <= ready_next;
    end

    // result monitor: values seen here are those present at the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // idle cycles before the next word: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one word and wait until the block takes it
    task automatic send_word(logic [2:0] op, logic on, logic [12:0] addr, logic [7:0] wd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, wd, addr, on};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, on, addr, wd);
    endtask

    // vram addresses: a small hot region at each end so reads find earlier writes
    function automatic logic [12:0] pick_vram_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 13'($urandom_range(0, 31));
        if (r < 50) return 13'($urandom_range(VRAM_SIZE - 32, VRAM_SIZE - 1));
        return 13'($urandom);
    endfunction

    // oam addresses: mostly in range, some around the top edge, some anywhere
    function automatic logic [12:0] pick_oam_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 13'($urandom_range(0, OAM_SIZE - 1));
        if (r < 85) return 13'($urandom_range(OAM_SIZE - 10, OAM_SIZE + 10));
        return 13'($urandom);
    endfunction

    // one random word; shares are out of 1000
    task automatic send_random(int on_share, int off_share);
        int r, k;
        logic [12:0] a;
        r = $urandom_range(0, 999);
        a = 13'($urandom);
        if (r < on_share) begin
            send_word(OP_TICK, 1'b1, a, 8'($urandom));
        end else if (r < on_share + off_share) begin
            send_word(OP_TICK, 1'b0, a, 8'($urandom));
        end else begin
            k = $urandom_range(0, 20);
            if (k < 5)
                send_word(OP_VRAM_RD, 1'($urandom), pick_vram_addr(), 8'($urandom));
            else if (k < 10)
                send_word(OP_VRAM_WR, 1'($urandom), pick_vram_addr(), 8'($urandom));
            else if (k < 15)
                send_word(OP_OAM_RD, 1'($urandom), pick_oam_addr(), 8'($urandom));
            else if (k < 20)
                send_word(OP_OAM_WR, 1'($urandom), pick_oam_addr(), 8'($urandom));
            else
                send_word(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                          1'($urandom), a, 8'($urandom));
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    // reprogram all registers once every owed result is back
    task automatic program_regs(logic [7:0] cmp_line, logic cmp_en, logic search_en);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(CFG_LINE_COMPARE, cmp_line);
        write_reg(CFG_COMPARE_IRQ_EN, {7'd0, cmp_en});
        write_reg(CFG_SEARCH_IRQ_EN, {7'd0, search_en});
        cfg_valid <= 1'b0;
    endtask

    // run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0] cmp_line;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // line 0 compare match armed, search request off
        program_regs(8'd0, 1'b1, 1'b0);

        // directed: idle display, store edges, lcd on/off, unused ops
        send_word(OP_TICK, 1'b0, 13'h1FFF, 8'hFF);      // stays disabled
        send_word(OP_VRAM_RD, 1'b1, 13'h0000, 8'h00);   // cleared store reads zero
        send_word(OP_VRAM_WR, 1'b0, 13'h1FFF, 8'hFF);
        send_word(OP_VRAM_RD, 1'b0, 13'h1FFF, 8'h00);
        send_word(OP_VRAM_WR, 1'b1, 13'h0000, 8'h5A);
        send_word(OP_OAM_WR, 1'b0, 13'(OAM_SIZE - 1), 8'hA5);
        send_word(OP_OAM_RD, 1'b0, 13'(OAM_SIZE - 1), 8'h00);
        send_word(OP_OAM_WR, 1'b0, 13'(OAM_SIZE), 8'h77);   // past the end, dropped
        send_word(OP_OAM_RD, 1'b0, 13'(OAM_SIZE), 8'h00);   // past the end reads 0xff
        send_word(OP_OAM_RD, 1'b0, 13'h1FFF, 8'h00);
        send_word(OP_OAM_RD, 1'b0, 13'h0000, 8'h00);
        send_word(OP_TICK, 1'b1, 13'h0000, 8'h00);      // enter search on line 0, match
        send_word(OP_OAM_RD, 1'b0, 13'(OAM_SIZE - 1), 8'h00);  // locked in search
        send_word(OP_OAM_WR, 1'b1, 13'h0000, 8'h33);    // dropped while locked
        send_word(OP_VRAM_RD, 1'b0, 13'h0000, 8'h00);   // vram still open in search
        send_word(OP_SPARE_FIRST, 1'b0, 13'h0000, 8'h00);
        send_word(OP_SPARE_FIRST + 3'd1, 1'b1, 13'h1FFF, 8'hFF);
        send_word(OP_SPARE_LAST, 1'b0, 13'h0ABC, 8'hFF);
        send_word(OP_TICK, 1'b0, 13'h0000, 8'h00);      // display off, line and phase held
        send_word(OP_TICK, 1'b0, 13'h0000, 8'h00);
        send_word(OP_VRAM_WR, 1'b0, 13'h0001, 8'h01);
        send_word(OP_OAM_WR, 1'b0, 13'h0000, 8'hC3);    // open while off
        send_word(OP_TICK, 1'b1, 13'h0000, 8'h00);      // restart from line 0

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: program_regs(8'd0, 1'b1, 1'b1);
                1: program_regs(8'd255, 1'b0, 1'b0);
                2: program_regs(8'd1, 1'b1, 1'b0);
                3: program_regs(8'd0, 1'b0, 1'b1);
                default: begin
                    cmp_line = 8'($urandom_range(0, 3));
                    program_regs(cmp_line, 1'($urandom), 1'($urandom));
                end
            endcase
            quiet = (p == 4);
            for (int i = 0; i < 190; i++) begin
                // back-pressure test: receiver holds off while words keep coming
                if (p == 2 && i == 50) long_holds_asked++;
                send_random(700, 10);
            end
        end

        // steady ticks from a fresh enable into line 1, compare armed on line 1
        program_regs(8'd1, 1'b1, 1'b0);
        quiet = 1'b1;
        send_word(OP_TICK, 1'b0, 13'h0000, 8'h00);
        for (int i = 0; i < 130; i++) begin
            if ($urandom_range(0, 9) == 0) send_random(0, 0);
            send_word(OP_TICK, 1'b1, 13'($urandom), 8'($urandom));
        end
        quiet = 1'b0;

        // drain
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d words in, %0d results checked, %0d stat requests, deepest line %0d",
                 sb.words_in, sb.checked, sb.irqs, sb.deepest_line);
        $display("modes seen %b, %0d reads refused by lockout or range",
                 sb.modes_seen, sb.refused_reads);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pmtvl_pkg.sv
hw/rtl/pmtvl_ram.sv
hw/rtl/pmtvl_timing.sv
hw/rtl/ppu_mode_timing_with_vram_lockout_unit.sv
hw/rtl/pmtvl_checker.sv
dv/tb.sv
